[hw/rtl/sszf_pkg.sv]
// Shared types, codes and constants of the sparse segment zero-fill decoder.
package sszf_pkg;

	localparam int DIGEST_BYTES = 20;
	localparam int HEADER_BYTES = 8;
	localparam int DIGEST_BITS  = DIGEST_BYTES * 8;
	localparam int QUEUE_DEPTH  = 4;

	// configuration register indexes
	localparam logic [1:0] CFG_COMP_LEN = 2'd0;
	localparam logic [1:0] CFG_DEC_LEN  = 2'd1;
	localparam logic [1:0] CFG_PRE_LEN  = 2'd2;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_RUN     = 2'd1,
		KIND_VERDICT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_INSEG    = 2'd2,
		ST_OVERRUN  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_DATA    = 2'd0,
		OP_RUN     = 2'd1,
		OP_VERDICT = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		BK_PASS,
		BK_PAD1,
		BK_HASH1,
		BK_HASH2,
		BK_EMIT
	} bk_state_t;

	// queue entry: data byte, zero run length, or verdict request with message length
	typedef struct packed {
		op_t         op;
		logic [31:0] arg;
		status_t     st;
	} q_entry_t;

	typedef struct packed {
		logic blk_go;
		logic h_init;
	} front_ctl_t;

	typedef struct packed {
		logic eng_free;
		logic verdict_done;
	} back_st_t;

	typedef logic [15:0][31:0] blk_t;
	typedef logic [4:0][31:0]  hash_t;

	localparam hash_t SHA_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	function automatic status_t set_err(status_t cur, status_t code);
		return (cur == ST_OK) ? code : cur;
	endfunction

endpackage

[hw/rtl/sszf_if.sv]
// Valid/ready channel interfaces for input bytes and result beats.
interface sszf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       chunk_start;
	modport source (output valid, output in_byte, output chunk_start, input ready);
	modport sink (input valid, input in_byte, input chunk_start, output ready);
endinterface

interface sszf_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [31:0] zero_run_length;
	logic [1:0]  status;
	modport source (output valid, output kind, output data_byte, output zero_run_length,
		output status, input ready);
	modport sink (input valid, input kind, input data_byte, input zero_run_length,
		input status, output ready);
endinterface

[hw/rtl/sszf_front.sv]
// Front end: accepts bytes, tracks chunk position and segments, queues result ops.
module sszf_front import sszf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	sszf_in_if.sink                in_ch,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [31:0]            cfg_data,
	output logic                   q_push,
	output q_entry_t               q_entry,
	input  logic                   q_room,
	output front_ctl_t             ctl,
	input  back_st_t               bst,
	output blk_t                   msg,
	output logic [DIGEST_BITS-1:0] exp_digest
);

	logic [31:0] comp_len_q, dec_len_q;
	logic [15:0] pre_len_q;
	logic [31:0] pos_q, oc_q, left_q;
	logic [55:0] hdr_q;
	logic [3:0]  hc_q;
	status_t     err_q;
	logic        vpend_q, blk_go_q, h_init_q;
	blk_t        msg_q;
	logic [DIGEST_BITS-1:0] exp_q;

	logic        acc, cs;
	logic [31:0] pos, oc, left, total, ds;
	logic [55:0] hdr;
	logic [3:0]  hc;
	status_t     err;
	logic [31:0] pos_n, oc_n, left_n;
	logic [55:0] hdr_n;
	logic [3:0]  hc_n;
	status_t     err_n;
	logic        msg_we, exp_we, go_n, vset;
	logic [31:0] off, size, need, room, run;
	logic [32:0] seg_end;
	logic        eng_ok;

	assign cs     = in_ch.chunk_start;
	assign eng_ok = bst.eng_free & ~blk_go_q;
	// block end and chunk restart both need the hash unit free
	assign in_ch.ready = q_room & ~vpend_q &
		(eng_ok | ((pos_q[5:0] != 6'h3f) & ~cs));
	assign acc = in_ch.valid & in_ch.ready;

	assign total = (comp_len_q < 32'(DIGEST_BYTES)) ? 32'(DIGEST_BYTES) : comp_len_q;
	assign ds    = total - 32'(DIGEST_BYTES);

	// classify one byte and work out the next chunk state
	always_comb begin
		pos  = cs ? '0 : pos_q;
		oc   = cs ? '0 : oc_q;
		left = cs ? '0 : left_q;
		hdr  = cs ? '0 : hdr_q;
		hc   = cs ? '0 : hc_q;
		err  = cs ? ST_OK : err_q;
		pos_n   = pos;
		oc_n    = oc;
		left_n  = left;
		hdr_n   = hdr;
		hc_n    = hc;
		err_n   = err;
		msg_we  = 1'b0;
		exp_we  = 1'b0;
		go_n    = 1'b0;
		vset    = 1'b0;
		q_push  = 1'b0;
		q_entry = '{op: OP_DATA, arg: '0, st: ST_OK};
		off     = {hdr[55:24]};
		size    = {hdr[23:0], in_ch.in_byte};
		need    = off - oc;
		room    = (dec_len_q > oc) ? dec_len_q - oc : '0;
		run     = '0;
		seg_end = {1'b0, off} + {1'b0, size};
		if (pos < total) begin
			pos_n = pos + 32'd1;
			if (pos >= ds) begin
				// digest bytes
				exp_we = 1'b1;
				if (pos == ds) begin
					if (hc != '0) err_n = set_err(err, ST_INSEG);
					if (oc < dec_len_q) begin
						q_push  = 1'b1;
						q_entry = '{op: OP_RUN, arg: dec_len_q - oc, st: ST_OK};
					end
					oc_n   = dec_len_q;
					hc_n   = '0;
					left_n = '0;
				end
				if (pos == total - 32'd1) begin
					vset    = 1'b1;
					q_push  = 1'b1;
					q_entry = '{op: OP_VERDICT, arg: ds, st: err_n};
				end
			end else begin
				msg_we = 1'b1;
				go_n   = (pos[5:0] == 6'h3f);
				if (pos >= {16'h0, pre_len_q}) begin
					if (hc < 4'(HEADER_BYTES)) begin
						// header byte
						hdr_n = {hdr[47:0], in_ch.in_byte};
						hc_n  = hc + 4'd1;
						if (hc == 4'(HEADER_BYTES - 1)) begin
							if (off >= oc) begin
								run = need;
								if (need > room) begin
									err_n = set_err(err, ST_OVERRUN);
									run   = room;
								end
								oc_n   = oc + run;
								left_n = size;
							end else begin
								left_n = (seg_end > {1'b0, oc}) ? 32'(seg_end - {1'b0, oc}) : '0;
							end
							hc_n = (left_n != '0) ? 4'(HEADER_BYTES) : '0;
							if (run != '0) begin
								q_push  = 1'b1;
								q_entry = '{op: OP_RUN, arg: run, st: ST_OK};
							end
						end
					end else begin
						// data byte of a segment
						left_n = left - 32'd1;
						if (left_n == '0) hc_n = '0;
						if (oc < dec_len_q) begin
							oc_n    = oc + 32'd1;
							q_push  = 1'b1;
							q_entry = '{op: OP_DATA, arg: {24'h0, in_ch.in_byte}, st: ST_OK};
						end else begin
							err_n = set_err(err, ST_OVERRUN);
						end
					end
				end
			end
		end
		q_push = q_push & acc;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_len_q <= 32'(DIGEST_BYTES);
			dec_len_q  <= '0;
			pre_len_q  <= '0;
			pos_q      <= '0;
			oc_q       <= '0;
			left_q     <= '0;
			hdr_q      <= '0;
			hc_q       <= '0;
			err_q      <= ST_OK;
			vpend_q    <= 1'b0;
			blk_go_q   <= 1'b0;
			h_init_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_COMP_LEN: comp_len_q <= cfg_data;
					CFG_DEC_LEN:  dec_len_q  <= cfg_data;
					CFG_PRE_LEN:  pre_len_q  <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (acc) begin
				pos_q  <= pos_n;
				oc_q   <= oc_n;
				left_q <= left_n;
				hdr_q  <= hdr_n;
				hc_q   <= hc_n;
				err_q  <= err_n;
			end
			if (acc && vset) vpend_q <= 1'b1;
			else if (bst.verdict_done) vpend_q <= 1'b0;
			blk_go_q <= acc & go_n;
			h_init_q <= acc & cs;
		end
	end

	// message block and expected digest bytes
	always_ff @(posedge clk) begin
		if (acc && msg_we) begin
			if (pos[1:0] == 2'd0) msg_q[pos[5:2]] <= {in_ch.in_byte, 24'h0};
			else msg_q[pos[5:2]] <= msg_q[pos[5:2]] |
				({in_ch.in_byte, 24'h0} >> {pos[1:0], 3'b000});
		end
		if (acc && exp_we) exp_q <= {exp_q[DIGEST_BITS-9:0], in_ch.in_byte};
	end

	assign ctl.blk_go = blk_go_q;
	assign ctl.h_init = h_init_q;
	assign msg        = msg_q;
	assign exp_digest = exp_q;

endmodule

[hw/rtl/sszf_queue.sv]
// Short FIFO of result ops between front and back end.
module sszf_queue import sszf_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t din,
	output logic     room,
	input  logic     pop,
	output logic     head_valid,
	output q_entry_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	assign room       = (cnt_q != CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

endmodule

[hw/rtl/sszf_back.sv]
// Back end: SHA-1 round unit, digest padding and verdict, result output register.
module sszf_back import sszf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  q_entry_t               q_head,
	output logic                   q_pop,
	input  front_ctl_t             ctl,
	output back_st_t               bst,
	input  blk_t                   msg,
	input  logic [DIGEST_BITS-1:0] exp_digest,
	sszf_out_if.source             out_ch
);

	bk_state_t   st_q, st_n;
	hash_t       h_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_q [16];
	logic [6:0]  rnd_q;
	logic        busy_q, fin_q;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  data_q;
	logic [31:0] run_q;
	status_t     stat_q;

	logic        slot_free, eng_idle, two_blk;
	logic        start, start_pad1, start_pad2, load_item, load_verdict;
	blk_t        pad1, pad2, src;
	logic [31:0] f, k, tmp, wnew, len, wmask;
	logic [5:0]  r;
	status_t     verdict;
	logic [DIGEST_BITS-1:0] h_bytes;

	assign slot_free = ~out_valid_q | out_ch.ready;
	assign eng_idle  = ~busy_q & ~ctl.blk_go;
	assign len       = q_head.arg;
	assign r         = len[5:0];
	assign two_blk   = (r >= 6'd56);

	// padded final block(s) for a message of len bytes
	always_comb begin
		case (r[1:0])
			2'd0:    wmask = 32'h8000_0000;
			2'd1:    wmask = {msg[r[5:2]][31:24], 24'h80_0000};
			2'd2:    wmask = {msg[r[5:2]][31:16], 16'h8000};
			default: wmask = {msg[r[5:2]][31:8], 8'h80};
		endcase
		for (int i = 0; i < 16; i++) begin
			if (4'(i) < r[5:2])       pad1[i] = msg[i];
			else if (4'(i) == r[5:2]) pad1[i] = wmask;
			else                      pad1[i] = '0;
			pad2[i] = '0;
		end
		pad2[14] = {29'h0, len[31:29]};
		pad2[15] = {len[28:0], 3'b000};
		if (!two_blk) begin
			pad1[14] = pad2[14];
			pad1[15] = pad2[15];
		end
	end

	// verdict sequencer: next state
	always_comb begin
		st_n = st_q;
		case (st_q)
			BK_PASS:  if (q_valid && q_head.op == OP_VERDICT) st_n = BK_PAD1;
			BK_PAD1:  if (eng_idle) st_n = BK_HASH1;
			BK_HASH1: if (!busy_q) st_n = two_blk ? BK_HASH2 : BK_EMIT;
			BK_HASH2: if (!busy_q) st_n = BK_EMIT;
			BK_EMIT:  if (slot_free) st_n = BK_PASS;
			default:  st_n = BK_PASS;
		endcase
	end

	// verdict sequencer: outputs
	always_comb begin
		start_pad1   = 1'b0;
		start_pad2   = 1'b0;
		load_item    = 1'b0;
		load_verdict = 1'b0;
		case (st_q)
			BK_PASS:  load_item = q_valid & (q_head.op != OP_VERDICT) & slot_free;
			BK_PAD1:  start_pad1 = eng_idle;
			BK_HASH1: start_pad2 = ~busy_q & two_blk;
			BK_EMIT:  load_verdict = slot_free;
			default: ;
		endcase
		q_pop = load_item | load_verdict;
	end

	assign start = ctl.blk_go | start_pad1 | start_pad2;
	assign src   = ctl.blk_go ? msg : (start_pad2 ? pad2 : pad1);

	// round function
	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = 32'h5A82_7999;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = 32'h6ED9_EBA1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = 32'h8F1B_BCDC;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = 32'hCA62_C1D6;
		end
		tmp  = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		wnew = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		wnew = {wnew[30:0], wnew[31]};
	end

	// SHA-1 unit: one round a cycle, then the chaining add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			rnd_q  <= '0;
			h_q    <= SHA_INIT;
		end else if (start) begin
			busy_q <= 1'b1;
			fin_q  <= 1'b0;
			rnd_q  <= '0;
		end else if (busy_q && fin_q) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			h_q[0] <= h_q[0] + a_q;
			h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q;
		end else if (busy_q) begin
			rnd_q <= rnd_q + 7'd1;
			if (rnd_q == 7'd79) fin_q <= 1'b1;
		end else if (ctl.h_init) begin
			h_q <= SHA_INIT;
		end
	end

	// working variables and schedule window
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
			for (int i = 0; i < 16; i++) w_q[i] <= src[i];
		end else if (busy_q && !fin_q) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end
	end

	// digest in byte order: word 0 first, as the expected digest arrives
	assign h_bytes = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};

	assign verdict = (q_head.st != ST_OK) ? q_head.st :
		((h_bytes == exp_digest) ? ST_OK : ST_MISMATCH);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			st_q        <= BK_PASS;
		end else begin
			st_q <= st_n;
			if (load_item || load_verdict) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_item) begin
			kind_q <= (q_head.op == OP_DATA) ? KIND_DATA : KIND_RUN;
			data_q <= (q_head.op == OP_DATA) ? q_head.arg[7:0] : '0;
			run_q  <= (q_head.op == OP_RUN) ? q_head.arg : '0;
			stat_q <= ST_OK;
		end else if (load_verdict) begin
			kind_q <= KIND_VERDICT;
			data_q <= '0;
			run_q  <= '0;
			stat_q <= verdict;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.kind            = kind_q;
	assign out_ch.data_byte       = data_q;
	assign out_ch.zero_run_length = run_q;
	assign out_ch.status          = stat_q;

	assign bst.eng_free     = ~busy_q;
	assign bst.verdict_done = load_verdict;

endmodule

[hw/rtl/sparse_segment_zero_fill_decoder.sv]
// Top level of the sparse segment zero-fill decoder with SHA-1 check.
//
//  channel  | dir | beat payload                                  | accepted when
//  ---------+-----+-----------------------------------------------+------------------
//  in_ch    | in  | in_byte, chunk_start                          | valid && ready
//  out_ch   | out | kind, data_byte, zero_run_length, status      | valid && ready
//  cfg      | in  | cfg_index, cfg_data (0 comp, 1 dec, 2 prefix) | cfg_we
//
// Bytes are taken one a cycle, but stall at a block end or chunk start until the SHA-1 unit is free;
// each 64-byte block goes through issue, 80 rounds, chaining add and restart in the SHA-1 unit.
// After the last byte of a chunk the verdict waits while one or two padding blocks are hashed;
// input stalls until it is in the output register.
// Input also stalls when the op queue is full. Reset clears all control state and
// loads the configuration and hash state with their reset values.
module sparse_segment_zero_fill_decoder import sszf_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	sszf_in_if.sink     in_ch,
	sszf_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic                   q_push, q_room, q_pop, q_valid;
	q_entry_t               q_din, q_head;
	front_ctl_t             ctl;
	back_st_t               bst;
	blk_t                   msg;
	logic [DIGEST_BITS-1:0] exp_digest;

	sszf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_push     (q_push),
		.q_entry    (q_din),
		.q_room     (q_room),
		.ctl        (ctl),
		.bst        (bst),
		.msg        (msg),
		.exp_digest (exp_digest)
	);

	sszf_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.din        (q_din),
		.room       (q_room),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	sszf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.ctl        (ctl),
		.bst        (bst),
		.msg        (msg),
		.exp_digest (exp_digest),
		.out_ch     (out_ch)
	);

endmodule

[hw/rtl/sszf_chk.sv]
// Port-level checker for the decoder output channel, bound to the top level.
module sszf_chk import sszf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        o_valid,
	input logic        o_ready,
	input logic [1:0]  o_kind,
	input logic [7:0]  o_data,
	input logic [31:0] o_run,
	input logic [1:0]  o_status
);

	// a zero run beat never carries an empty run
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_kind == KIND_RUN |-> o_run != '0)
		else $error("zero run of length zero");

	// only a verdict carries a status
	a_status_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && o_kind != KIND_VERDICT |-> o_status == ST_OK)
		else $error("status on a non-verdict beat");

	// unused payload fields are zero
	a_fields_clean: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid |-> (o_kind == KIND_DATA || o_data == '0) &&
		(o_kind == KIND_RUN || o_run == '0))
		else $error("stray payload bits");

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_ready |=> o_valid &&
		$stable({o_kind, o_data, o_run, o_status}))
		else $error("output beat changed while stalled");

endmodule

bind sparse_segment_zero_fill_decoder sszf_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.o_valid  (out_ch.valid),
	.o_ready  (out_ch.ready),
	.o_kind   (out_ch.kind),
	.o_data   (out_ch.data_byte),
	.o_run    (out_ch.zero_run_length),
	.o_status (out_ch.status)
);

[sim/tb_top.sv]
// Self-checking testbench of the sparse segment zero-fill decoder with SHA-1 check.
module tb_top;
	import sszf_pkg::*;

	typedef struct {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [31:0] run;
		status_t     status;
	} beat_t;

	// Expected-beat store plus a bit-accurate model of the decoder
	class sszf_scoreboard;
		beat_t       exp_q[$];
		int          errors;
		bit [31:0]   comp_len, dec_len;
		bit [15:0]   pre_len;
		bit [31:0]   pos, out_cnt;
		bit [63:0]   hdr;
		int          hdr_cnt;
		hash_t       hw;
		blk_t        mblk;
		hash_t       dig;
		status_t     err;

		function new();
			comp_len = DIGEST_BYTES;
			dec_len  = 0;
			pre_len  = 0;
			errors   = 0;
			clear_chunk();
		endfunction

		function void clear_chunk();
			pos = 0; out_cnt = 0; hdr = 0; hdr_cnt = 0;
			hw = SHA_INIT; mblk = '0; dig = '0; err = ST_OK;
		endfunction

		function void set_reg(logic [1:0] idx, bit [31:0] val);
			case (idx)
				CFG_COMP_LEN: comp_len = val;
				CFG_DEC_LEN:  dec_len  = val;
				CFG_PRE_LEN:  pre_len  = val[15:0];
				default: ;
			endcase
		endfunction

		static function hash_t sha_round(hash_t h, blk_t blk);
			bit [31:0] w[80];
			bit [31:0] a, b, c, d, e, f, k, t;
			for (int i = 0; i < 16; i++) w[i] = blk[i];
			for (int i = 16; i < 80; i++) begin
				t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
				w[i] = {t[30:0], t[31]};
			end
			a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
			for (int i = 0; i < 80; i++) begin
				if (i < 20) begin
					f = (b & c) | (~b & d); k = 32'h5A827999;
				end else if (i < 40) begin
					f = b ^ c ^ d; k = 32'h6ED9EBA1;
				end else if (i < 60) begin
					f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
				end else begin
					f = b ^ c ^ d; k = 32'hCA62C1D6;
				end
				t = {a[26:0], a[31:27]} + f + e + k + w[i];
				e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
			end
			h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
			return h;
		endfunction

		// SHA-1 of a whole byte string, used to build chunks with a good digest
		static function hash_t sha_of(byte unsigned msg[$]);
			byte unsigned m[$];
			hash_t h;
			blk_t  blk;
			bit [63:0] bits;
			m = msg;
			bits = 64'(msg.size()) * 8;
			m.push_back(8'h80);
			while (m.size() % 64 != 56) m.push_back(8'h00);
			for (int i = 7; i >= 0; i--) m.push_back(bits[8*i +: 8]);
			h = SHA_INIT;
			for (int o = 0; o < m.size(); o += 64) begin
				for (int i = 0; i < 16; i++)
					blk[i] = {m[o+4*i], m[o+4*i+1], m[o+4*i+2], m[o+4*i+3]};
				h = sha_round(h, blk);
			end
			return h;
		endfunction

		// finish the running hash for a message of len bytes and compare
		function bit digest_ok(bit [31:0] len);
			hash_t h;
			blk_t  blk;
			bit [5:0] r;
			int wi, sub;
			bit [63:0] bits;
			h = hw; blk = mblk;
			r = len[5:0]; wi = r >> 2; sub = r & 3;
			bits = 64'(len) * 8;
			if (sub == 0) blk[wi] = 32'h80000000;
			else blk[wi] = (blk[wi] & (32'hFFFFFFFF << (32 - 8*sub))) |
				(32'h80 << (24 - 8*sub));
			for (int i = wi + 1; i < 16; i++) blk[i] = 0;
			if (r >= 56) begin
				h = sha_round(h, blk);
				blk = '0;
			end
			blk[14] = bits[63:32];
			blk[15] = bits[31:0];
			h = sha_round(h, blk);
			return h == dig;
		endfunction

		function void flag(status_t code);
			if (err == ST_OK) err = code;
		endfunction

		function void push(kind_t k, bit [7:0] db, bit [31:0] run, status_t st);
			beat_t x;
			x.kind = k; x.data_byte = db; x.run = run; x.status = st;
			exp_q.push_back(x);
		endfunction

		// accepted input byte: advance the model, queue any resulting beat
		function void note_byte(bit [7:0] b, bit start);
			bit [31:0] total, ds, p, k, fill, off, size, need, room, run;
			bit [32:0] seg_end;
			bit [63:0] left;
			total = (comp_len < DIGEST_BYTES) ? DIGEST_BYTES : comp_len;
			ds = total - DIGEST_BYTES;
			if (start) clear_chunk();
			p = pos;
			if (p >= total) return;
			pos = p + 1;
			if (p >= ds) begin
				k = p - ds;
				if (k[1:0] == 0) dig[k >> 2] = {b, 24'h0};
				else dig[k >> 2] |= 32'(b) << (24 - 8*k[1:0]);
				if (k == 0) begin
					fill = 0;
					if (hdr_cnt != 0) flag(ST_INSEG);
					if (out_cnt < dec_len) fill = dec_len - out_cnt;
					out_cnt = dec_len;
					hdr_cnt = 0;
					hdr = 0;
					if (fill != 0) begin
						push(KIND_RUN, 0, fill, ST_OK);
						return;
					end
				end
				if (p == total - 1)
					push(KIND_VERDICT, 0, 0,
						err != ST_OK ? err : (digest_ok(ds) ? ST_OK : ST_MISMATCH));
				return;
			end
			// every byte before the digest is hashed
			if (p[1:0] == 0) mblk[p[5:2]] = {b, 24'h0};
			else mblk[p[5:2]] |= 32'(b) << (24 - 8*p[1:0]);
			if (p[5:0] == 6'd63) hw = sha_round(hw, mblk);
			if (p < pre_len) return;
			if (hdr_cnt < HEADER_BYTES) begin
				hdr = {hdr[55:0], b};
				hdr_cnt++;
				if (hdr_cnt == HEADER_BYTES) begin
					off = hdr[63:32];
					size = hdr[31:0];
					seg_end = 33'(off) + size;
					run = 0;
					if (off >= out_cnt) begin
						need = off - out_cnt;
						room = dec_len > out_cnt ? dec_len - out_cnt : 0;
						left = size;
						run = need;
						if (need > room) begin
							flag(ST_OVERRUN);
							run = room;
						end
						out_cnt += run;
					end else begin
						left = seg_end > out_cnt ? seg_end - out_cnt : 0;
					end
					hdr = left;
					hdr_cnt = left != 0 ? HEADER_BYTES : 0;
					if (run != 0) push(KIND_RUN, 0, run, ST_OK);
				end
				return;
			end
			// data phase of a segment
			hdr--;
			if (hdr == 0) hdr_cnt = 0;
			if (out_cnt < dec_len) begin
				out_cnt++;
				push(KIND_DATA, b, 0, ST_OK);
			end else begin
				flag(ST_OVERRUN);
			end
		endfunction

		function void check_beat(logic [1:0] k, logic [7:0] db, logic [31:0] run,
			logic [1:0] st);
			beat_t x;
			if (exp_q.size() == 0) begin
				$display("%0t: unexpected beat kind=%0d byte=%h run=%h status=%0d",
					$time, k, db, run, st);
				errors++;
				return;
			end
			x = exp_q.pop_front();
			if (k !== x.kind || db !== x.data_byte || run !== x.run || st !== x.status) begin
				$display("%0t: mismatch expected kind=%0d byte=%h run=%h status=%0d",
					$time, x.kind, x.data_byte, x.run, x.status);
				$display("%0t:          actual   kind=%0d byte=%h run=%h status=%0d",
					$time, k, db, run, st);
				errors++;
			end
		endfunction
	endclass

	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE = 250;
	localparam int N_ITEMS = 1850;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	sszf_in_if  in_ch();
	sszf_out_if out_ch();

	sparse_segment_zero_fill_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sszf_scoreboard sb = new();
	int  sent;
	int  hold_left;
	int  stall_left;
	int  idle_cnt;
	bit  quiet;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// monitors: note accepted bytes, check accepted result beats
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			sb.note_byte(in_ch.in_byte, in_ch.chunk_start);
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_beat(out_ch.kind, out_ch.data_byte, out_ch.zero_run_length,
				out_ch.status);
	end

	// receiver: random stalls, occasional long ones, and a long hold when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if (quiet) begin
			out_ch.ready <= 1'b1;
		end else begin
			if ($urandom_range(0, 99) < 2) stall_left = $urandom_range(10, 60);
			out_ch.ready <= $urandom_range(0, 99) >= 30;
		end
	end

	// watchdog on cycles with no beat accepted on either side
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt > IDLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic put_byte(bit [7:0] b, bit start);
		int g;
		in_ch.valid       <= 1'b1;
		in_ch.in_byte     <= b;
		in_ch.chunk_start <= start;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent++;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic write_regs(bit [31:0] comp, bit [31:0] dec, bit [15:0] pre);
		cfg_we <= 1'b1; cfg_index <= CFG_COMP_LEN; cfg_data <= comp;
		@(posedge clk);
		cfg_index <= CFG_DEC_LEN; cfg_data <= dec;
		@(posedge clk);
		cfg_index <= CFG_PRE_LEN; cfg_data <= 32'(pre);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(CFG_COMP_LEN, comp);
		sb.set_reg(CFG_DEC_LEN, dec);
		sb.set_reg(CFG_PRE_LEN, 32'(pre));
	endtask

	// all expected beats in, then room for a verdict still in flight
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.exp_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_all(byte unsigned q[$]);
		foreach (q[i]) put_byte(q[i], i == 0);
	endtask

	// well-formed chunk with random content, optionally broken
	// bad: corrupt digest, cut: end inside a segment, short: decoded size too small
	task automatic run_chunk(int pre, int nseg, bit bad, bit cut, bit short_dec,
		int extra);
		byte unsigned q[$];
		bit [31:0] cur, off, size, ndata;
		bit [32:0] e;
		int dec;
		hash_t h;
		int fb;
		cur = 0;
		repeat (pre) q.push_back($urandom_range(0, 255));
		repeat (nseg) begin
			if (cur > 0 && $urandom_range(0, 7) == 0) off = $urandom_range(0, cur - 1);
			else off = cur + $urandom_range(0, 20);
			size = $urandom_range(0, 12);
			for (int i = 3; i >= 0; i--) q.push_back(off[8*i +: 8]);
			for (int i = 3; i >= 0; i--) q.push_back(size[8*i +: 8]);
			e = 33'(off) + size;
			if (off >= cur) ndata = size;
			else ndata = e > cur ? e - cur : 0;
			repeat (ndata) q.push_back($urandom_range(0, 255));
			if (e > cur) cur = e;
		end
		if (cut) repeat ($urandom_range(1, 7)) q.push_back($urandom_range(0, 255));
		dec = cur + $urandom_range(0, 15);
		if (short_dec && cur > 0) dec = $urandom_range(0, cur - 1);
		h = sszf_scoreboard::sha_of(q);
		if (bad) begin
			fb = $urandom_range(0, 159);
			h[fb / 32][fb % 32] = ~h[fb / 32][fb % 32];
		end
		for (int i = 0; i < 5; i++)
			for (int j = 3; j >= 0; j--) q.push_back(h[i][8*j +: 8]);
		write_regs(q.size(), dec, pre);
		repeat (extra) q.push_back($urandom_range(0, 255));
		send_all(q);
		drain();
	endtask

	// random bytes against random settings, mostly short, with stray restarts
	task automatic noise_chunk();
		int n;
		write_regs($urandom_range(0, 60),
			$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 100),
			$urandom_range(0, 40));
		n = $urandom_range(1, 70);
		for (int i = 0; i < n; i++)
			put_byte($urandom_range(0, 255), i == 0 || $urandom_range(0, 39) == 0);
		drain();
	endtask

	initial begin
		byte unsigned q[$];
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.chunk_start = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_COMP_LEN;
		cfg_data = 32'h0;
		sent = 0;
		hold_left = 0;
		idle_cnt = 0;
		quiet = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: digest only, short length register, prefix into digest
		run_chunk(0, 0, 0, 0, 0, 0);
		write_regs(32'd5, 32'd3, 16'd0);
		repeat (20) put_byte(8'hFF, sent == 20 ? 1'b1 : 1'b0);
		drain();
		write_regs(32'd24, 32'd0, 16'd30);
		for (int i = 0; i < 24; i++) put_byte(8'h00, i == 0);
		drain();
		// extreme settings; chunk never ends, the next start clears it
		write_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
		put_byte(8'hFF, 1'b1);
		put_byte(8'h00, 1'b0);
		drain();
		write_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 16'h0000);
		q = '{8'hFF, 8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h02, 8'hAB, 8'h55};
		send_all(q);
		drain();
		quiet = 1'b0;
		// segments with good and bad digest, cut segment, overrun, trailing bytes
		run_chunk(4, 2, 0, 0, 0, 3);
		run_chunk(0, 2, 1, 0, 0, 0);
		run_chunk(0, 1, 0, 1, 0, 0);
		run_chunk(0, 2, 0, 0, 1, 0);

		// long hold on the result side while bytes keep coming
		hold_left = 400;
		run_chunk(2, 14, 0, 0, 0, 0);

		while (sent < N_ITEMS) begin
			quiet = $urandom_range(0, 5) == 0;
			case ($urandom_range(0, 9))
				0: noise_chunk();
				1: run_chunk($urandom_range(0, 10), $urandom_range(0, 6), 1, 0, 0, 0);
				2: run_chunk(0, $urandom_range(1, 5), 0, 1, 0, 0);
				3: run_chunk($urandom_range(0, 4), $urandom_range(1, 6), 0, 0, 1,
					$urandom_range(0, 3));
				default: run_chunk($urandom_range(0, 8), $urandom_range(0, 8), 0, 0, 0,
					$urandom_range(0, 1));
			endcase
		end
		drain();

		if (sb.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
